// File: hdl/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prq_pkg
// Shared types and codes of the process ready/blocked queue scheduler.
// ---------------------------------------------------------------------------
package prq_pkg;

    localparam int KIND_W   = 4;
    localparam int SLOT_W   = 4;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        K_CREATE   = 4'd0,
        K_INSERT   = 4'd1,
        K_REMOVE   = 4'd2,
        K_SUSPEND  = 4'd3,
        K_RESUME   = 4'd4,
        K_BLOCK    = 4'd5,
        K_UNBLOCK  = 4'd6,
        K_SETPRIO  = 4'd7,
        K_DISPATCH = 4'd8,
        K_SAVE     = 4'd9,
        K_RELEASE  = 4'd10,
        K_QUERY    = 4'd11
    } kind_t;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_READY   = 2'd1,
        ST_BLOCKED = 2'd2
    } run_state_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NOSLOT = 2'd1,
        STATUS_BADARG = 2'd2
    } status_t;

    // per-half write enables of one link entry
    typedef struct packed {
        logic next_we;
        logic prev_we;
    } link_we_t;

endpackage
`default_nettype wire

// File: hdl/prq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prq_ram
// Generic single write / single read RAM, bit write mask, registered read.
// ---------------------------------------------------------------------------
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [WIDTH-1:0]         wmask,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        for (int i = 0; i < WIDTH; i++) begin
            if (we && wmask[i]) begin
                mem[waddr][i] <= wdata[i];
            end
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hdl/prq_link_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prq_link_mem
// Queue link store: next/prev per slot in one RAM, entries read as null
// until first written.
// ---------------------------------------------------------------------------
module prq_link_mem
    import prq_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    localparam int IW = $clog2(NUM_SLOTS),
    localparam int LW = $clog2(NUM_SLOTS + 1)
) (
    input  wire logic          clk,
    input  wire logic          rstn,
    input  wire link_we_t      wr,
    input  wire logic [IW-1:0] waddr,
    input  wire logic [LW-1:0] wnext,
    input  wire logic [LW-1:0] wprev,
    input  wire logic [IW-1:0] raddr,
    output logic      [LW-1:0] rnext,
    output logic      [LW-1:0] rprev
);

    localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

    logic              ok_reg [NUM_SLOTS];
    logic              ok_rd_reg;
    logic              we;
    logic              fresh;
    logic [2*LW-1:0]   wmask;
    logic [2*LW-1:0]   wdata;
    logic [2*LW-1:0]   rdata;

    // first write to an entry fills the untouched half with null
    assign fresh = !ok_reg[waddr];
    assign we    = wr.next_we || wr.prev_we;
    assign wmask = {{LW{wr.next_we || fresh}}, {LW{wr.prev_we || fresh}}};
    assign wdata = {(wr.next_we ? wnext : NIL), (wr.prev_we ? wprev : NIL)};

    prq_ram #(
        .WIDTH (2 * LW),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .wmask (wmask),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk) begin
        if (!rstn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                ok_reg[i] <= 1'b0;
            end
            ok_rd_reg <= 1'b0;
        end else begin
            if (we) begin
                ok_reg[waddr] <= 1'b1;
            end
            ok_rd_reg <= ok_reg[raddr];
        end
    end

    assign rnext = ok_rd_reg ? rdata[2*LW-1:LW] : NIL;
    assign rprev = ok_rd_reg ? rdata[LW-1:0]    : NIL;

endmodule
`default_nettype wire

// File: hdl/process_ready_blocked_queues.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// process_ready_blocked_queues
// Process slot table with a priority ready queue and a FIFO blocked queue.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    kind, slot, priority_req, proc_class,
//                                    stack_ptr
//  m_        out  m_valid/m_ready    status, found, slot_out, priority_out,
//                                    state_out, suspended_out, class_out,
//                                    stack_ptr_out, queued_out, counts
//
//  One command at a time.
//  The longest command is an unlink of a queued slot (3 link writes), then a
//  priority insert walking up to NUM_SLOTS - 1 ready entries, one read each.
//  Dispatch also walks past suspended entries.
//  Reset clears valid bits, queue heads and counts at once; no clearing pass.
//  A result held by m_ready low stalls the next command only at its end.
// ---------------------------------------------------------------------------
module process_ready_blocked_queues
    import prq_pkg::*;
#(
    parameter int NUM_SLOTS    = 16,
    parameter int MAX_PRIORITY = 9,
    parameter int STACK_WIDTH  = 32,
    localparam int LW = $clog2(NUM_SLOTS + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [KIND_W-1:0]      s_kind,
    input  wire logic [SLOT_W-1:0]      s_slot,
    input  wire logic [PRIO_W-1:0]      s_priority_req,
    input  wire logic                   s_proc_class,
    input  wire logic [STACK_WIDTH-1:0] s_stack_ptr,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [STATUS_W-1:0]         m_status,
    output logic                        m_found,
    output logic [SLOT_W-1:0]           m_slot_out,
    output logic [PRIO_W-1:0]           m_priority_out,
    output logic [1:0]                  m_state_out,
    output logic                        m_suspended_out,
    output logic                        m_class_out,
    output logic [STACK_WIDTH-1:0]      m_stack_ptr_out,
    output logic                        m_queued_out,
    output logic [LW-1:0]               m_ready_count,
    output logic [LW-1:0]               m_blocked_count
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

    typedef struct packed {
        logic [PRIO_W-1:0]      prio;
        run_state_t             rstate;
        logic                   susp;
        logic                   cls;
        logic [STACK_WIDTH-1:0] stack;
    } info_t;

    localparam int INFO_W = $bits(info_t);

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_CHECK     = 15'h0002,
        S_DSP_CK    = 15'h0004,
        S_UL_A      = 15'h0008,
        S_UL_B      = 15'h0010,
        S_UL_C      = 15'h0020,
        S_POST      = 15'h0040,
        S_INS_START = 15'h0080,
        S_WALK_CK   = 15'h0100,
        S_INS_A     = 15'h0200,
        S_INS_B     = 15'h0400,
        S_INS_C     = 15'h0800,
        S_APP_A     = 15'h1000,
        S_APP_B     = 15'h2000,
        S_FIN       = 15'h4000
    } fsm_t;

    fsm_t                   state_reg, state_next;

    kind_t                  kind_reg;
    logic [PRIO_W-1:0]      pr_reg;
    logic [STACK_WIDTH-1:0] stk_reg;
    status_t                status_reg;
    logic                   report_reg;

    logic [IW-1:0]          x_reg;
    logic [PRIO_W-1:0]      x_prio_reg;
    run_state_t             x_state_reg;
    logic                   x_susp_reg;
    logic                   x_cls_reg;
    logic [STACK_WIDTH-1:0] x_stack_reg;
    logic [LW-1:0]          x_next_reg;
    logic [LW-1:0]          x_prev_reg;
    logic [LW-1:0]          c_reg;
    logic [LW-1:0]          p_reg;

    logic [LW-1:0]          rhead_reg, rtail_reg, bhead_reg, btail_reg;
    logic [LW-1:0]          rcnt_reg, bcnt_reg;
    logic                   valid_reg [NUM_SLOTS];
    logic                   m_valid_reg;

    // RAM ports
    logic                   info_we;
    info_t                  info_mask, info_wdata, rinfo;
    logic [INFO_W-1:0]      info_rdata;
    logic [IW-1:0]          info_waddr;
    link_we_t               link_we;
    logic [IW-1:0]          link_waddr;
    logic [LW-1:0]          link_wnext, link_wprev;
    logic [LW-1:0]          rnext, rprev;
    logic [IW-1:0]          rd_addr;

    logic [7:0]             slot_wide;
    logic [IW-1:0]          s_idx;
    logic                   s_inrange, s_ok, create_ok;
    logic [LW-1:0]          x_ext;
    logic                   rd_q, x_blk;
    logic [LW-1:0]          app_tail;
    logic                   fin_go;

    assign slot_wide = 8'(s_slot);
    assign s_idx     = slot_wide[IW-1:0];
    assign s_inrange = 32'(s_slot) < NUM_SLOTS;
    assign s_ok      = s_inrange && valid_reg[s_idx];
    assign create_ok = s_inrange && !valid_reg[s_idx] &&
                       (32'(s_priority_req) <= MAX_PRIORITY);
    assign x_ext     = LW'(x_reg);
    assign rinfo     = info_t'(info_rdata);
    // queued: has a link, or is alone at the head of a queue
    assign rd_q      = (rnext != NIL) || (rprev != NIL) ||
                       (rhead_reg == x_ext) || (bhead_reg == x_ext);
    assign x_blk     = x_state_reg == ST_BLOCKED;
    assign app_tail  = x_blk ? btail_reg : rtail_reg;
    assign fin_go    = !m_valid_reg || m_ready;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

    prq_ram #(
        .WIDTH (INFO_W),
        .DEPTH (NUM_SLOTS)
    ) u_info_ram (
        .clk   (aclk),
        .we    (info_we),
        .wmask (info_mask),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .raddr (rd_addr),
        .rdata (info_rdata)
    );

    prq_link_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_link_mem (
        .clk   (aclk),
        .rstn  (aresetn),
        .wr    (link_we),
        .waddr (link_waddr),
        .wnext (link_wnext),
        .wprev (link_wprev),
        .raddr (rd_addr),
        .rnext (rnext),
        .rprev (rprev)
    );

    always_comb begin
        state_next = state_reg;
        info_we    = 1'b0;
        info_mask  = '0;
        info_wdata = '0;
        info_waddr = x_reg;
        link_we    = '0;
        link_waddr = x_reg;
        link_wnext = NIL;
        link_wprev = NIL;
        rd_addr    = x_reg;
        case (state_reg)
            S_IDLE: begin
                rd_addr = s_idx;
                if (s_valid) begin
                    if (s_kind > K_QUERY) begin
                        state_next = S_FIN;
                    end else if (s_kind == K_CREATE) begin
                        if (create_ok) begin
                            info_we           = 1'b1;
                            info_mask         = '1;
                            info_waddr        = s_idx;
                            info_wdata.prio   = s_priority_req;
                            info_wdata.rstate = ST_READY;
                            info_wdata.susp   = 1'b0;
                            info_wdata.cls    = s_proc_class;
                            info_wdata.stack  = s_stack_ptr;
                            link_we           = '{next_we: 1'b1, prev_we: 1'b1};
                            link_waddr        = s_idx;
                        end
                        state_next = S_FIN;
                    end else if (s_kind == K_DISPATCH) begin
                        if (rhead_reg == NIL) begin
                            state_next = S_FIN;
                        end else begin
                            rd_addr    = rhead_reg[IW-1:0];
                            state_next = S_DSP_CK;
                        end
                    end else if (!s_ok) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                case (kind_reg)
                    K_INSERT: begin
                        if (rinfo.rstate == ST_RUNNING || rd_q) state_next = S_FIN;
                        else state_next = S_INS_START;
                    end
                    K_REMOVE: state_next = rd_q ? S_UL_A : S_FIN;
                    K_BLOCK, K_UNBLOCK: state_next = rd_q ? S_UL_A : S_POST;
                    K_SETPRIO: begin
                        if (rinfo.prio == pr_reg || 32'(pr_reg) > MAX_PRIORITY) begin
                            state_next = S_FIN;
                        end else begin
                            state_next = rd_q ? S_UL_A : S_POST;
                        end
                    end
                    K_SAVE, K_RELEASE: state_next = rd_q ? S_FIN : S_POST;
                    K_SUSPEND, K_RESUME, K_QUERY: state_next = S_POST;
                    default: state_next = S_FIN;
                endcase
            end
            S_DSP_CK: begin
                if (rinfo.susp) begin
                    if (rnext == NIL) begin
                        state_next = S_FIN;
                    end else begin
                        rd_addr = rnext[IW-1:0];
                    end
                end else begin
                    state_next = S_UL_A;
                end
            end
            S_UL_A: begin
                link_we    = '{next_we: 1'b1, prev_we: 1'b1};
                state_next = S_UL_B;
            end
            S_UL_B: begin
                if (x_prev_reg != NIL) begin
                    link_we.next_we = 1'b1;
                    link_waddr      = x_prev_reg[IW-1:0];
                    link_wnext      = x_next_reg;
                end
                state_next = S_UL_C;
            end
            S_UL_C: begin
                if (x_next_reg != NIL) begin
                    link_we.prev_we = 1'b1;
                    link_waddr      = x_next_reg[IW-1:0];
                    link_wprev      = x_prev_reg;
                end
                state_next = S_POST;
            end
            S_POST: begin
                state_next = S_FIN;
                case (kind_reg)
                    K_SUSPEND, K_RESUME: begin
                        info_we         = 1'b1;
                        info_mask.susp  = 1'b1;
                        info_wdata.susp = kind_reg == K_SUSPEND;
                    end
                    K_BLOCK, K_UNBLOCK: begin
                        info_we           = 1'b1;
                        info_mask.rstate  = run_state_t'(2'b11);
                        info_wdata.rstate = (kind_reg == K_BLOCK) ? ST_BLOCKED : ST_READY;
                        state_next        = S_INS_START;
                    end
                    K_SETPRIO: begin
                        info_we         = 1'b1;
                        info_mask.prio  = '1;
                        info_wdata.prio = pr_reg;
                        if (x_state_reg != ST_RUNNING) state_next = S_INS_START;
                    end
                    K_SAVE: begin
                        info_we           = 1'b1;
                        info_mask.rstate  = run_state_t'(2'b11);
                        info_mask.stack   = '1;
                        info_wdata.rstate = ST_READY;
                        info_wdata.stack  = stk_reg;
                        state_next        = S_INS_START;
                    end
                    K_INSERT: state_next = S_INS_START;
                    K_DISPATCH: begin
                        info_we           = 1'b1;
                        info_mask.rstate  = run_state_t'(2'b11);
                        info_wdata.rstate = ST_RUNNING;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_INS_START: begin
                if (x_blk || rhead_reg == NIL) begin
                    state_next = S_APP_A;
                end else begin
                    rd_addr    = rhead_reg[IW-1:0];
                    state_next = S_WALK_CK;
                end
            end
            S_WALK_CK: begin
                if (rinfo.prio < x_prio_reg) begin
                    state_next = S_INS_A;
                end else if (rnext == NIL) begin
                    state_next = S_APP_A;
                end else begin
                    rd_addr = rnext[IW-1:0];
                end
            end
            S_INS_A: begin
                link_we    = '{next_we: 1'b1, prev_we: 1'b1};
                link_wnext = c_reg;
                link_wprev = p_reg;
                state_next = S_INS_B;
            end
            S_INS_B: begin
                if (p_reg != NIL) begin
                    link_we.next_we = 1'b1;
                    link_waddr      = p_reg[IW-1:0];
                    link_wnext      = x_ext;
                end
                state_next = S_INS_C;
            end
            S_INS_C: begin
                link_we.prev_we = 1'b1;
                link_waddr      = c_reg[IW-1:0];
                link_wprev      = x_ext;
                state_next      = S_FIN;
            end
            S_APP_A: begin
                link_we    = '{next_we: 1'b1, prev_we: 1'b1};
                link_wprev = app_tail;
                state_next = S_APP_B;
            end
            S_APP_B: begin
                if (app_tail != NIL) begin
                    link_we.next_we = 1'b1;
                    link_waddr      = app_tail[IW-1:0];
                    link_wnext      = x_ext;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (fin_go) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rhead_reg   <= NIL;
            rtail_reg   <= NIL;
            bhead_reg   <= NIL;
            btail_reg   <= NIL;
            rcnt_reg    <= '0;
            bcnt_reg    <= '0;
            report_reg  <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FIN && fin_go) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg   <= kind_t'(s_kind);
                        pr_reg     <= s_priority_req;
                        stk_reg    <= s_stack_ptr;
                        x_reg      <= s_idx;
                        report_reg <= 1'b0;
                        if (s_kind > K_QUERY) begin
                            status_reg <= STATUS_BADARG;
                        end else if (s_kind == K_CREATE) begin
                            if (create_ok) begin
                                valid_reg[s_idx] <= 1'b1;
                                status_reg       <= STATUS_OK;
                            end else begin
                                status_reg <= STATUS_BADARG;
                            end
                        end else if (s_kind == K_DISPATCH) begin
                            status_reg <= (rhead_reg == NIL) ? STATUS_NOSLOT : STATUS_OK;
                            c_reg      <= rhead_reg;
                        end else begin
                            status_reg <= s_ok ? STATUS_OK : STATUS_NOSLOT;
                        end
                    end
                end
                S_CHECK: begin
                    x_prio_reg  <= rinfo.prio;
                    x_state_reg <= rinfo.rstate;
                    x_susp_reg  <= rinfo.susp;
                    x_cls_reg   <= rinfo.cls;
                    x_stack_reg <= rinfo.stack;
                    x_next_reg  <= rnext;
                    x_prev_reg  <= rprev;
                    case (kind_reg)
                        K_INSERT: begin
                            if (rinfo.rstate == ST_RUNNING || rd_q) status_reg <= STATUS_BADARG;
                        end
                        K_SETPRIO: begin
                            if (rinfo.prio != pr_reg && 32'(pr_reg) > MAX_PRIORITY) begin
                                status_reg <= STATUS_BADARG;
                            end
                        end
                        K_SAVE, K_RELEASE: begin
                            if (rd_q) status_reg <= STATUS_BADARG;
                        end
                        default: ;
                    endcase
                end
                S_DSP_CK: begin
                    if (rinfo.susp) begin
                        if (rnext == NIL) status_reg <= STATUS_NOSLOT;
                        c_reg <= rnext;
                    end else begin
                        x_reg       <= c_reg[IW-1:0];
                        x_prio_reg  <= rinfo.prio;
                        x_state_reg <= rinfo.rstate;
                        x_susp_reg  <= rinfo.susp;
                        x_cls_reg   <= rinfo.cls;
                        x_stack_reg <= rinfo.stack;
                        x_next_reg  <= rnext;
                        x_prev_reg  <= rprev;
                    end
                end
                S_UL_A: begin
                    if (x_blk) begin
                        if (x_prev_reg == NIL) bhead_reg <= x_next_reg;
                        if (x_next_reg == NIL) btail_reg <= x_prev_reg;
                        if (bcnt_reg != '0) bcnt_reg <= bcnt_reg - 1'b1;
                    end else begin
                        if (x_prev_reg == NIL) rhead_reg <= x_next_reg;
                        if (x_next_reg == NIL) rtail_reg <= x_prev_reg;
                        if (rcnt_reg != '0) rcnt_reg <= rcnt_reg - 1'b1;
                    end
                end
                S_UL_C: begin
                    x_next_reg <= NIL;
                    x_prev_reg <= NIL;
                end
                S_POST: begin
                    case (kind_reg)
                        K_SUSPEND:  x_susp_reg  <= 1'b1;
                        K_RESUME:   x_susp_reg  <= 1'b0;
                        K_BLOCK:    x_state_reg <= ST_BLOCKED;
                        K_UNBLOCK:  x_state_reg <= ST_READY;
                        K_SETPRIO: begin
                            x_prio_reg <= pr_reg;
                            if (x_state_reg == ST_RUNNING) status_reg <= STATUS_BADARG;
                        end
                        K_SAVE: begin
                            x_state_reg <= ST_READY;
                            x_stack_reg <= stk_reg;
                        end
                        K_RELEASE:  valid_reg[x_reg] <= 1'b0;
                        K_QUERY:    report_reg <= 1'b1;
                        K_DISPATCH: begin
                            x_state_reg <= ST_RUNNING;
                            report_reg  <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_INS_START: c_reg <= rhead_reg;
                S_WALK_CK: begin
                    if (rinfo.prio < x_prio_reg) p_reg <= rprev;
                    else c_reg <= rnext;
                end
                S_INS_A: begin
                    x_next_reg <= c_reg;
                    x_prev_reg <= p_reg;
                end
                S_INS_B: begin
                    if (p_reg == NIL) rhead_reg <= x_ext;
                end
                S_INS_C: rcnt_reg <= rcnt_reg + 1'b1;
                S_APP_A: begin
                    x_next_reg <= NIL;
                    x_prev_reg <= app_tail;
                end
                S_APP_B: begin
                    if (x_blk) begin
                        if (btail_reg == NIL) bhead_reg <= x_ext;
                        btail_reg <= x_ext;
                        bcnt_reg  <= bcnt_reg + 1'b1;
                    end else begin
                        if (rtail_reg == NIL) rhead_reg <= x_ext;
                        rtail_reg <= x_ext;
                        rcnt_reg  <= rcnt_reg + 1'b1;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        m_status        <= status_reg;
                        m_found         <= report_reg && kind_reg == K_DISPATCH;
                        m_slot_out      <= report_reg ? SLOT_W'(x_reg) : '0;
                        m_priority_out  <= report_reg ? x_prio_reg : '0;
                        m_state_out     <= report_reg ? x_state_reg : 2'b00;
                        m_suspended_out <= report_reg && x_susp_reg;
                        m_class_out     <= report_reg && x_cls_reg;
                        m_stack_ptr_out <= report_reg ? x_stack_reg : '0;
                        m_queued_out    <= report_reg &&
                                           ((x_next_reg != NIL) || (x_prev_reg != NIL) ||
                                            (rhead_reg == x_ext) || (bhead_reg == x_ext));
                        m_ready_count   <= rcnt_reg;
                        m_blocked_count <= bcnt_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/prq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prq_checker
// Port-level checks of the scheduler result channel, bound to the top.
// ---------------------------------------------------------------------------
module prq_checker
    import prq_pkg::*;
#(
    parameter int NUM_SLOTS   = 16,
    parameter int STACK_WIDTH = 32,
    localparam int LW = $clog2(NUM_SLOTS + 1)
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [STATUS_W-1:0]    m_status,
    input wire logic                   m_found,
    input wire logic [SLOT_W-1:0]      m_slot_out,
    input wire logic [1:0]             m_state_out,
    input wire logic                   m_suspended_out,
    input wire logic [STACK_WIDTH-1:0] m_stack_ptr_out,
    input wire logic                   m_queued_out,
    input wire logic [LW-1:0]          m_ready_count,
    input wire logic [LW-1:0]          m_blocked_count
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_out) &&
        $stable(m_ready_count) && $stable(m_blocked_count))
        else $error("result item changed while stalled");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_status == STATUS_OK)
        else $error("dispatch found with error status");

    a_err_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |->
        !m_found && m_slot_out == '0 && m_stack_ptr_out == '0 && !m_queued_out)
        else $error("report fields set on failed command");

    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_ready_count) + 32'(m_blocked_count) <= NUM_SLOTS)
        else $error("queue counts exceed slot count");

    a_dispatched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |->
        m_state_out == ST_RUNNING && !m_suspended_out && !m_queued_out)
        else $error("dispatched slot not running and dequeued");

endmodule

bind process_ready_blocked_queues prq_checker #(
    .NUM_SLOTS   (NUM_SLOTS),
    .STACK_WIDTH (STACK_WIDTH)
) u_prq_checker (.*);
`default_nettype wire

// File: test/tb_process_ready_blocked_queues.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_process_ready_blocked_queues
// Self-checking bench for the process scheduler: a directed table of
// scheduler commands, then weighted random command streams. Every result is
// checked against a behavioral scheduler model kept in the bench.
// ---------------------------------------------------------------------------
module tb_process_ready_blocked_queues;
    import prq_pkg::*;

    localparam int NSLOT      = 16;
    localparam int NIL        = 16;
    localparam int MAXPRIO    = 9;
    localparam int RAND_ITEMS = 1430;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 300;
    localparam logic [3:0] KIND_UNKNOWN = 4'd15;

    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic [3:0]  slot;
        logic [3:0]  prio;
        logic [1:0]  state;
        logic        susp;
        logic        cls;
        logic [31:0] stack;
        logic        queued;
        logic [4:0]  rcount;
        logic [4:0]  bcount;
        // values typed into the table, checked on top of the model
        bit          pinned;
        logic [1:0]  pin_status;
        logic [4:0]  pin_rcount;
        logic [4:0]  pin_bcount;
    } sched_result_t;

    typedef struct {
        logic [3:0]  kind;
        logic [3:0]  slot;
        logic [3:0]  prio;
        logic        cls;
        logic [31:0] stack;
        bit          pinned;
        logic [1:0]  pin_status;
        logic [4:0]  pin_rcount;
        logic [4:0]  pin_bcount;
    } cmd_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [3:0]  s_kind = '0;
    logic [3:0]  s_slot = '0;
    logic [3:0]  s_priority_req = '0;
    logic        s_proc_class = 0;
    logic [31:0] s_stack_ptr = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic        m_found;
    logic [3:0]  m_slot_out;
    logic [3:0]  m_priority_out;
    logic [1:0]  m_state_out;
    logic        m_suspended_out;
    logic        m_class_out;
    logic [31:0] m_stack_ptr_out;
    logic        m_queued_out;
    logic [4:0]  m_ready_count;
    logic [4:0]  m_blocked_count;

    always #2 aclk = ~aclk;

    process_ready_blocked_queues u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_slot(s_slot),
        .s_priority_req(s_priority_req), .s_proc_class(s_proc_class),
        .s_stack_ptr(s_stack_ptr),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_found(m_found), .m_slot_out(m_slot_out),
        .m_priority_out(m_priority_out), .m_state_out(m_state_out),
        .m_suspended_out(m_suspended_out), .m_class_out(m_class_out),
        .m_stack_ptr_out(m_stack_ptr_out), .m_queued_out(m_queued_out),
        .m_ready_count(m_ready_count), .m_blocked_count(m_blocked_count)
    );

    // ---------------- scheduler model ----------------
    logic        valid_r [NSLOT];
    logic [3:0]  prio_r  [NSLOT];
    logic [1:0]  state_r [NSLOT];
    logic        susp_r  [NSLOT];
    logic        cls_r   [NSLOT];
    logic [31:0] stk_r   [NSLOT];
    int          nxt [NSLOT];
    int          prv [NSLOT];
    int          rhead, rtail, bhead, btail, rtot, btot;

    function automatic bit is_queued(int s);
        return prv[s] != NIL || nxt[s] != NIL || rhead == s || bhead == s;
    endfunction

    function automatic void unlink(int s);
        bit blk;
        int p;
        int n;
        blk = state_r[s] == ST_BLOCKED;
        p = prv[s];
        n = nxt[s];
        if (p < NIL) nxt[p] = n;
        else if (blk) bhead = n;
        else rhead = n;
        if (n < NIL) prv[n] = p;
        else if (blk) btail = p;
        else rtail = p;
        prv[s] = NIL;
        nxt[s] = NIL;
        if (blk) begin
            if (btot > 0) btot--;
        end else begin
            if (rtot > 0) rtot--;
        end
    endfunction

    function automatic void insert_by_prio(int s);
        int c;
        int g;
        int p;
        c = rhead;
        g = 0;
        while (c < NIL && g < NSLOT) begin
            if (prio_r[c] < prio_r[s]) begin
                p = prv[c];
                nxt[s] = c;
                prv[s] = p;
                if (p < NIL) nxt[p] = s; else rhead = s;
                prv[c] = s;
                rtot++;
                return;
            end
            c = nxt[c];
            g++;
        end
        nxt[s] = NIL;
        prv[s] = rtail;
        if (rtail < NIL) nxt[rtail] = s; else rhead = s;
        rtail = s;
        rtot++;
    endfunction

    function automatic logic [1:0] enqueue(int s);
        if (state_r[s] == ST_RUNNING || is_queued(s)) return STATUS_BADARG;
        if (state_r[s] == ST_BLOCKED) begin
            nxt[s] = NIL;
            prv[s] = btail;
            if (btail < NIL) nxt[btail] = s; else bhead = s;
            btail = s;
            btot++;
        end else begin
            insert_by_prio(s);
        end
        return STATUS_OK;
    endfunction

    function automatic void describe_slot(inout sched_result_t r, input int s);
        r.slot   = s[3:0];
        r.prio   = prio_r[s];
        r.state  = state_r[s];
        r.susp   = susp_r[s];
        r.cls    = cls_r[s];
        r.stack  = stk_r[s];
        r.queued = is_queued(s);
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < NSLOT; i++) begin
            valid_r[i] = 0;
            prio_r[i] = '0;
            state_r[i] = '0;
            susp_r[i] = 0;
            cls_r[i] = 0;
            stk_r[i] = '0;
            nxt[i] = NIL;
            prv[i] = NIL;
        end
        rhead = NIL; rtail = NIL; bhead = NIL; btail = NIL;
        rtot = 0; btot = 0;
    endfunction

    function automatic sched_result_t sched_next(logic [3:0] kind, int s,
                                                 int pr, logic cls,
                                                 logic [31:0] stk);
        sched_result_t r;
        int c;
        int g;
        r = '{default: '0};
        r.status = STATUS_OK;
        if (kind > K_QUERY) begin
            r.status = STATUS_BADARG;
        end else if (kind == K_CREATE) begin
            if (valid_r[s] || pr > MAXPRIO) begin
                r.status = STATUS_BADARG;
            end else begin
                valid_r[s] = 1;
                prio_r[s] = pr[3:0];
                cls_r[s] = cls;
                state_r[s] = ST_READY;
                susp_r[s] = 0;
                stk_r[s] = stk;
                nxt[s] = NIL;
                prv[s] = NIL;
            end
        end else if (kind == K_DISPATCH) begin
            c = rhead;
            g = 0;
            while (c < NIL && g < NSLOT && susp_r[c]) begin
                c = nxt[c];
                g++;
            end
            if (c < NIL && !susp_r[c]) begin
                unlink(c);
                state_r[c] = ST_RUNNING;
                r.found = 1;
                describe_slot(r, c);
            end else begin
                r.status = STATUS_NOSLOT;
            end
        end else if (!valid_r[s]) begin
            r.status = STATUS_NOSLOT;
        end else begin
            case (kind)
                K_INSERT: r.status = enqueue(s);
                K_REMOVE: if (is_queued(s)) unlink(s);
                K_SUSPEND: susp_r[s] = 1;
                K_RESUME: susp_r[s] = 0;
                K_BLOCK, K_UNBLOCK: begin
                    if (is_queued(s)) unlink(s);
                    state_r[s] = (kind == K_BLOCK) ? ST_BLOCKED : ST_READY;
                    r.status = enqueue(s);
                end
                K_SETPRIO: begin
                    if (prio_r[s] == pr) r.status = STATUS_OK;
                    else if (pr > MAXPRIO) r.status = STATUS_BADARG;
                    else begin
                        if (is_queued(s)) unlink(s);
                        prio_r[s] = pr[3:0];
                        r.status = enqueue(s);
                    end
                end
                K_SAVE: begin
                    if (is_queued(s)) r.status = STATUS_BADARG;
                    else begin
                        state_r[s] = ST_READY;
                        stk_r[s] = stk;
                        r.status = enqueue(s);
                    end
                end
                K_RELEASE: begin
                    if (is_queued(s)) r.status = STATUS_BADARG;
                    else valid_r[s] = 0;
                end
                default: describe_slot(r, s);
            endcase
        end
        r.rcount = rtot[4:0];
        r.bcount = btot[4:0];
        return r;
    endfunction

    // ---------------- checking ----------------
    sched_result_t pending_results[$];
    int errors = 0;
    int items_in = 0;
    int results_out = 0;
    int dispatch_hits = 0;
    int idle_cycles = 0;
    cmd_row_t cur;

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        sched_result_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_out++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    e = pending_results.pop_front();
                    if (m_found) dispatch_hits++;
                    if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                    if (m_found !== e.found) report_mismatch("found", m_found, e.found);
                    if (m_slot_out !== e.slot) report_mismatch("slot_out", m_slot_out, e.slot);
                    if (m_priority_out !== e.prio)
                        report_mismatch("priority_out", m_priority_out, e.prio);
                    if (m_state_out !== e.state)
                        report_mismatch("state_out", m_state_out, e.state);
                    if (m_suspended_out !== e.susp)
                        report_mismatch("suspended_out", m_suspended_out, e.susp);
                    if (m_class_out !== e.cls)
                        report_mismatch("class_out", m_class_out, e.cls);
                    if (m_stack_ptr_out !== e.stack)
                        report_mismatch("stack_ptr_out", m_stack_ptr_out, e.stack);
                    if (m_queued_out !== e.queued)
                        report_mismatch("queued_out", m_queued_out, e.queued);
                    if (m_ready_count !== e.rcount)
                        report_mismatch("ready_count", m_ready_count, e.rcount);
                    if (m_blocked_count !== e.bcount)
                        report_mismatch("blocked_count", m_blocked_count, e.bcount);
                    if (e.pinned && (m_status !== e.pin_status ||
                                     m_ready_count !== e.pin_rcount ||
                                     m_blocked_count !== e.pin_bcount))
                        report_mismatch("table entry status/counts",
                                        {m_status, m_ready_count, m_blocked_count},
                                        {e.pin_status, e.pin_rcount, e.pin_bcount});
                end
            end
            if (s_valid && s_ready) begin
                items_in++;
                e = sched_next(s_kind, s_slot, s_priority_req, s_proc_class, s_stack_ptr);
                e.pinned = cur.pinned;
                e.pin_status = cur.pin_status;
                e.pin_rcount = cur.pin_rcount;
                e.pin_bcount = cur.pin_bcount;
                pending_results.push_back(e);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------- receiver ----------------
    int rx_stall_pct = 0;
    int tx_idle_pct = 0;
    bit hold_req = 0;
    int hold_left = 0;

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 0;
        end else begin
            m_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------- sender ----------------
    cmd_row_t dir_tab[25];

    task automatic send_cmd(cmd_row_t c);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        cur = c;
        s_kind = c.kind;
        s_slot = c.slot;
        s_priority_req = c.prio;
        s_proc_class = c.cls;
        s_stack_ptr = c.stack;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic cmd_row_t random_cmd();
        cmd_row_t c;
        int r;
        c = '{default: '0};
        r = $urandom_range(99);
        if (r < 14) c.kind = K_CREATE;
        else if (r < 24) c.kind = K_INSERT;
        else if (r < 30) c.kind = K_REMOVE;
        else if (r < 36) c.kind = K_SUSPEND;
        else if (r < 44) c.kind = K_RESUME;
        else if (r < 52) c.kind = K_BLOCK;
        else if (r < 60) c.kind = K_UNBLOCK;
        else if (r < 67) c.kind = K_SETPRIO;
        else if (r < 82) c.kind = K_DISPATCH;
        else if (r < 88) c.kind = K_SAVE;
        else if (r < 93) c.kind = K_RELEASE;
        else if (r < 98) c.kind = K_QUERY;
        else c.kind = 4'($urandom_range(12, 15));
        c.slot = 4'($urandom_range(15));
        c.prio = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                          : 4'($urandom_range(MAXPRIO));
        c.cls = 1'($urandom);
        c.stack = $urandom;
        return c;
    endfunction

    initial begin
        dir_tab = '{
            '{K_QUERY,    4'd0,  4'd0,  1'b0, 32'h0,        1, STATUS_NOSLOT, 5'd0, 5'd0},
            '{K_DISPATCH, 4'd0,  4'd0,  1'b0, 32'h0,        1, STATUS_NOSLOT, 5'd0, 5'd0},
            '{KIND_UNKNOWN, 4'd3, 4'd2, 1'b1, 32'h5,        1, STATUS_BADARG, 5'd0, 5'd0},
            '{K_CREATE,   4'd0,  4'd10, 1'b0, 32'h0,        1, STATUS_BADARG, 5'd0, 5'd0},
            '{K_CREATE,   4'd0,  4'd9,  1'b1, 32'hFFFFFFFF, 1, STATUS_OK,     5'd0, 5'd0},
            '{K_CREATE,   4'd15, 4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd0, 5'd0},
            '{K_CREATE,   4'd0,  4'd4,  1'b0, 32'h1,        1, STATUS_BADARG, 5'd0, 5'd0},
            '{K_INSERT,   4'd0,  4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd1, 5'd0},
            '{K_INSERT,   4'd0,  4'd0,  1'b0, 32'h0,        1, STATUS_BADARG, 5'd1, 5'd0},
            '{K_INSERT,   4'd15, 4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd2, 5'd0},
            '{K_SUSPEND,  4'd0,  4'd0,  1'b0, 32'h0,        0, 0, 0, 0},
            '{K_DISPATCH, 4'd0,  4'd0,  1'b0, 32'h0,        0, 0, 0, 0},
            '{K_SAVE,     4'd15, 4'd0,  1'b0, 32'hA5A55A5A, 0, 0, 0, 0},
            '{K_RESUME,   4'd0,  4'd0,  1'b0, 32'h0,        0, 0, 0, 0},
            '{K_SETPRIO,  4'd15, 4'd9,  1'b0, 32'h0,        0, 0, 0, 0},
            '{K_SETPRIO,  4'd15, 4'd15, 1'b0, 32'h0,        1, STATUS_BADARG, 5'd2, 5'd0},
            '{K_BLOCK,    4'd0,  4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd1, 5'd1},
            '{K_UNBLOCK,  4'd0,  4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd2, 5'd0},
            '{K_REMOVE,   4'd15, 4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd1, 5'd0},
            '{K_REMOVE,   4'd15, 4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd1, 5'd0},
            '{K_RELEASE,  4'd15, 4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd1, 5'd0},
            '{K_QUERY,    4'd15, 4'd0,  1'b0, 32'h0,        1, STATUS_NOSLOT, 5'd1, 5'd0},
            '{K_DISPATCH, 4'd0,  4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd0, 5'd0},
            '{K_SETPRIO,  4'd0,  4'd3,  1'b0, 32'h0,        1, STATUS_BADARG, 5'd0, 5'd0},
            '{K_RELEASE,  4'd0,  4'd0,  1'b0, 32'h0,        1, STATUS_OK,     5'd0, 5'd0}
        };
        sched_reset();
        cur = '{default: '0};
        repeat (8) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        foreach (dir_tab[i]) send_cmd(dir_tab[i]);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            case (n / 286)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
                3: begin tx_idle_pct = 28; rx_stall_pct = 28; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            // long receiver hold-off while items keep coming
            if (n == 100) hold_req = 1;
            // sender pause until everything is back
            if (n == 700) begin
                s_valid = 0;
                while (pending_results.size() != 0) @(negedge aclk);
            end
            send_cmd(random_cmd());
        end
        s_valid = 0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("Ran %0d scheduler commands, %0d results checked, %0d dispatches found work.",
                 items_in, results_out, dispatch_hits);
        $display("Directed table plus weighted random commands under varied stalls.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
